FILE: rtl/core/fmprc_pkg.sv
// Package for the first-match packet rule classifier: codes, rule entry types
// and the small match helper functions.
// No dependencies.
`default_nettype none

package fmprc_pkg;

  localparam int RULE_DEPTH_DEF = 64;
  localparam int ADDR_BITS      = 32;

  // Action codes of an input word.
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_CHECK = 2'd2;

  // Status codes of a result word.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Protocol codes.
  localparam logic [7:0] PROTO_ICMP  = 8'd1;
  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_ANY   = 8'd143;
  localparam logic [7:0] PROTO_OTHER = 8'd255;

  localparam logic [1:0] DIR_UNSET = 2'd0;
  localparam logic [1:0] DIR_ANY   = 2'd3;
  localparam logic [1:0] ACK_UNSET = 2'd0;
  localparam logic [1:0] ACK_ANY   = 2'd3;

  localparam logic [15:0] PORT_WILD = 16'd0;
  localparam logic [15:0] PORT_HIGH = 16'd1023;
  localparam logic [5:0]  PREFIX_MAX = 6'd32;

  typedef struct packed {
    logic [ADDR_BITS-1:0] src_ip;
    logic [ADDR_BITS-1:0] dst_ip;
  } rule_addr_t;

  typedef struct packed {
    logic [7:0]  protocol;
    logic [1:0]  direction;
    logic [5:0]  src_prefix;
    logic [5:0]  dst_prefix;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [1:0]  ack_flag;
    logic        verdict;
  } rule_fields_t;

  // Network mask for a stored prefix length of 0 to 32; zero means any address.
  function automatic logic [ADDR_BITS-1:0] prefix_mask(input logic [5:0] plen);
    logic [ADDR_BITS-1:0] mask;
    if (plen == 6'd0) begin
      mask = '0;
    end else begin
      mask = {ADDR_BITS{1'b1}} << (PREFIX_MAX - plen);
    end
    return mask;
  endfunction

  // A rule port of zero matches anything; the top port code matches it or above.
  function automatic logic port_fits(input logic [15:0] rport,
                                     input logic [15:0] pkt_port);
    logic fits;
    if (rport == PORT_WILD) begin
      fits = 1'b1;
    end else if (rport == PORT_HIGH) begin
      fits = (pkt_port >= PORT_HIGH);
    end else begin
      fits = (rport == pkt_port);
    end
    return fits;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fmprc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fmprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/first_match_packet_rule_classifier_core.sv
// Top level of the first-match packet rule classifier.
// Depends on fmprc_pkg and fmprc_ram.
`default_nettype none

// The block keeps an ordered table of up to RULE_DEPTH firewall rules in two
// on-chip RAMs (addresses and the remaining rule fields) and handles one
// input word at a time. An add word validates the rule and appends it, a
// clear word empties the table, and a check word scans the stored rules in
// order and reports the first one that matches the packet together with its
// verdict. Every input word yields exactly one result word. Add, clear and
// unused action words pass from acceptance through the finish state into
// the output register, and the next input word can be taken once the result
// has moved there. A check ends its scan early when a rule matches: the scan
// reads one rule per cycle through the single read port of the RAMs, with
// the registered read ahead of the compare, and the finish state moves the
// result out. The input stays stalled from acceptance until the result moves
// into the output register, and longer while that register holds a word the
// receiver has not yet taken. The output register holds a finished result
// word while the block accepts and works on the next input word. No clearing
// pass is needed after reset, since only entries below the rule count are
// ever read.

module first_match_packet_rule_classifier_core #(
  parameter int RULE_DEPTH = fmprc_pkg::RULE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  protocol,
  input  wire logic [1:0]  direction,
  input  wire logic [31:0] src_ip,
  input  wire logic [5:0]  src_prefix,
  input  wire logic [31:0] dst_ip,
  input  wire logic [5:0]  dst_prefix,
  input  wire logic [15:0] sport,
  input  wire logic [15:0] dport,
  input  wire logic [1:0]  ack_flag,
  input  wire logic        verdict,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [5:0]       rule_index,
  output logic             match_verdict,
  output logic [6:0]       rules_held
);

  localparam int IDX_W = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
  localparam int CNT_W = $clog2(RULE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RULE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state;

  // Control state.
  logic [CNT_W-1:0] rule_total;
  logic [CNT_W-1:0] rd_idx;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;

  // Packet under check, held for the length of the scan.
  logic [7:0]  pkt_protocol;
  logic [1:0]  pkt_direction;
  logic [31:0] pkt_src_ip;
  logic [31:0] pkt_dst_ip;
  logic [15:0] pkt_sport;
  logic [15:0] pkt_dport;
  logic [1:0]  pkt_ack_flag;

  // Result waiting to move into the output register.
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_index;
  logic             res_verdict;

  logic accept;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // ---------------------------------------------------------------------------
  // Rule validation for add words. A rule is checked before the table space.
  // ---------------------------------------------------------------------------
  logic proto_ok;
  logic rule_ok;
  logic table_full;
  logic wr_en;

  always_comb begin
    unique case (protocol) inside
      fmprc_pkg::PROTO_ICMP, fmprc_pkg::PROTO_TCP, fmprc_pkg::PROTO_UDP,
      fmprc_pkg::PROTO_ANY, fmprc_pkg::PROTO_OTHER: proto_ok = 1'b1;
      default:                                      proto_ok = 1'b0;
    endcase
  end

  assign rule_ok = proto_ok &&
                   (direction != fmprc_pkg::DIR_UNSET) &&
                   (src_prefix <= fmprc_pkg::PREFIX_MAX) &&
                   (dst_prefix <= fmprc_pkg::PREFIX_MAX) &&
                   (sport <= fmprc_pkg::PORT_HIGH) &&
                   (dport <= fmprc_pkg::PORT_HIGH) &&
                   (ack_flag != fmprc_pkg::ACK_UNSET);

  assign table_full = (rule_total == DEPTH_CNT);

  // New rules land at the slot just past the last stored rule.
  assign wr_en = accept && (action == fmprc_pkg::ACT_ADD) && rule_ok && !table_full;

  // ---------------------------------------------------------------------------
  // Rule storage. Writes happen only in the idle state and reads only while
  // scanning, so a read never meets a write to the same entry and no
  // forwarding path is needed.
  // ---------------------------------------------------------------------------
  fmprc_pkg::rule_addr_t   wr_addr_word;
  fmprc_pkg::rule_fields_t wr_field_word;
  fmprc_pkg::rule_addr_t   rule_a;
  fmprc_pkg::rule_fields_t rule_f;
  logic                    rd_en;

  assign wr_addr_word.src_ip     = src_ip;
  assign wr_addr_word.dst_ip     = dst_ip;
  assign wr_field_word.protocol  = protocol;
  assign wr_field_word.direction = direction;
  assign wr_field_word.src_prefix = src_prefix;
  assign wr_field_word.dst_prefix = dst_prefix;
  assign wr_field_word.sport     = sport;
  assign wr_field_word.dport     = dport;
  assign wr_field_word.ack_flag  = ack_flag;
  assign wr_field_word.verdict   = verdict;

  // Keep issuing reads until every stored rule has been fetched.
  assign rd_en = (state == S_SCAN) && (rd_idx != rule_total);

  fmprc_ram #(
    .WIDTH ($bits(fmprc_pkg::rule_addr_t)),
    .DEPTH (RULE_DEPTH)
  ) u_addr_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rule_total[IDX_W-1:0]),
    .wr_data (wr_addr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rule_a)
  );

  fmprc_ram #(
    .WIDTH ($bits(fmprc_pkg::rule_fields_t)),
    .DEPTH (RULE_DEPTH)
  ) u_field_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rule_total[IDX_W-1:0]),
    .wr_data (wr_field_word),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rule_f)
  );

  // ---------------------------------------------------------------------------
  // Match logic on the rule that came out of the RAMs this cycle.
  // ---------------------------------------------------------------------------
  logic proto_hit;
  logic dir_hit;
  logic src_hit;
  logic dst_hit;
  logic ports_hit;
  logic ack_hit;
  logic rule_hit;
  logic pkt_l4;

  assign pkt_l4 = (pkt_protocol == fmprc_pkg::PROTO_TCP) ||
                  (pkt_protocol == fmprc_pkg::PROTO_UDP);

  assign proto_hit = (rule_f.protocol == fmprc_pkg::PROTO_ANY) ||
                     (rule_f.protocol == pkt_protocol);
  assign dir_hit   = (rule_f.direction == fmprc_pkg::DIR_ANY) ||
                     (rule_f.direction == pkt_direction);

  // A zero rule address or a zero prefix matches any address.
  assign src_hit = (rule_a.src_ip == '0) ||
                   (((rule_a.src_ip ^ pkt_src_ip) &
                     fmprc_pkg::prefix_mask(rule_f.src_prefix)) == '0);
  assign dst_hit = (rule_a.dst_ip == '0) ||
                   (((rule_a.dst_ip ^ pkt_dst_ip) &
                     fmprc_pkg::prefix_mask(rule_f.dst_prefix)) == '0);

  // Ports only count for TCP and UDP packets, the ack bit only for TCP.
  assign ports_hit = !pkt_l4 ||
                     (fmprc_pkg::port_fits(rule_f.sport, pkt_sport) &&
                      fmprc_pkg::port_fits(rule_f.dport, pkt_dport));
  assign ack_hit   = (pkt_protocol != fmprc_pkg::PROTO_TCP) ||
                     (rule_f.ack_flag == fmprc_pkg::ACK_ANY) ||
                     (rule_f.ack_flag == pkt_ack_flag);

  assign rule_hit = proto_hit && dir_hit && src_hit && dst_hit && ports_hit && ack_hit;

  // ---------------------------------------------------------------------------
  // Sequencer and output register.
  // ---------------------------------------------------------------------------
  logic [CNT_W+6:0] total_ext;
  logic [IDX_W+5:0] index_ext;

  assign total_ext = {7'b0, rule_total};
  assign index_ext = {6'b0, res_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rule_total <= '0;
      rd_idx     <= '0;
      cmp_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // The finish state reloads the output register itself.
      if (out_valid && !out_stall && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_verdict <= 1'b0;
            cmp_valid   <= 1'b0;
            rd_idx      <= '0;
            unique case (action)
              fmprc_pkg::ACT_ADD: begin
                state <= S_FINISH;
                if (!rule_ok) begin
                  res_status <= fmprc_pkg::ST_INVALID;
                  res_index  <= '0;
                end else if (table_full) begin
                  res_status <= fmprc_pkg::ST_FULL;
                  res_index  <= '0;
                end else begin
                  res_status <= fmprc_pkg::ST_DONE;
                  res_index  <= rule_total[IDX_W-1:0];
                  rule_total <= rule_total + CNT_W'(1);
                end
              end
              fmprc_pkg::ACT_CLEAR: begin
                res_status <= fmprc_pkg::ST_DONE;
                res_index  <= '0;
                rule_total <= '0;
                state      <= S_FINISH;
              end
              fmprc_pkg::ACT_CHECK: begin
                pkt_protocol  <= protocol;
                pkt_direction <= direction;
                pkt_src_ip    <= src_ip;
                pkt_dst_ip    <= dst_ip;
                pkt_sport     <= sport;
                pkt_dport     <= dport;
                pkt_ack_flag  <= ack_flag;
                res_index     <= '0;
                state         <= S_SCAN;
              end
              default: begin
                res_status <= fmprc_pkg::ST_INVALID;
                res_index  <= '0;
                state      <= S_FINISH;
              end
            endcase
          end
        end

        S_SCAN: begin
          // Reads run one rule ahead of the compare.
          if (rd_en) begin
            rd_idx  <= rd_idx + CNT_W'(1);
            cmp_idx <= rd_idx[IDX_W-1:0];
          end
          if (cmp_valid && rule_hit) begin
            res_status  <= fmprc_pkg::ST_DONE;
            res_index   <= cmp_idx;
            res_verdict <= rule_f.verdict;
            cmp_valid   <= 1'b0;
            state       <= S_FINISH;
          end else if (rd_idx == rule_total) begin
            // Every rule has been compared, or the table is empty.
            res_status <= fmprc_pkg::ST_NO_MATCH;
            cmp_valid  <= 1'b0;
            state      <= S_FINISH;
          end else begin
            cmp_valid <= rd_en;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            rule_index    <= index_ext[5:0];
            match_verdict <= res_verdict;
            rules_held    <= total_ext[6:0];
            state         <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    rule_total <= DEPTH_CNT)
    else $error("rule count exceeds table depth");

  a_write_only_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE) && !table_full)
    else $error("rule write outside idle or into a full table");

  a_compare_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> (state == S_SCAN) && (CNT_W'(cmp_idx) < rule_total))
    else $error("rule compare outside the scan or beyond the stored rules");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (action == fmprc_pkg::ACT_CLEAR) |=> (rule_total == '0))
    else $error("clear word did not empty the table");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (rule_total == $past(rule_total) + CNT_W'(1)))
    else $error("accepted rule did not advance the rule count");

endmodule

`default_nettype wire
